### src/sccs_pkg.sv
// Shared types, register indexes and digit helpers for the settable clock.
// Used by every module of the block; depends on nothing.
package sccs_pkg;

	localparam int unsigned CFG_W = 10;

	localparam logic [0:0] REG_TIMEOUTS_PER_STEP = 1'b0;
	localparam logic [0:0] REG_LED_PHASE_STEPS   = 1'b1;

	localparam logic [9:0] TPS_RESET = 10'd10;
	localparam logic [9:0] LPS_RESET = 10'd16;

	localparam logic [6:0] SEG_BLANK = 7'h7F;

	localparam logic [1:0] SEL_SECONDS = 2'd1;
	localparam logic [1:0] SEL_MINUTES = 2'd2;
	localparam logic [1:0] SEL_HOURS   = 2'd3;

	typedef struct packed {
		logic        step;
		logic        button;
		logic [9:0]  switches;
		logic [9:0]  led;
		logic        halted;
	} sccs_item_t;

	typedef struct packed {
		logic        halted;
		logic [9:0]  led_pattern;
		logic [6:0]  seg_hour_tens;
		logic [6:0]  seg_hour_ones;
		logic [6:0]  seg_min_tens;
		logic [6:0]  seg_min_ones;
		logic [6:0]  seg_sec_tens;
		logic [6:0]  seg_sec_ones;
	} sccs_result_t;

	function automatic logic [6:0] seg_code(input logic [3:0] d);
		logic [6:0] c;
		case (d)
			4'd0: c = 7'h40;
			4'd1: c = 7'h79;
			4'd2: c = 7'h24;
			4'd3: c = 7'h30;
			4'd4: c = 7'h19;
			4'd5: c = 7'h12;
			4'd6: c = 7'h02;
			4'd7: c = 7'h78;
			4'd8: c = 7'h00;
			4'd9: c = 7'h10;
			default: c = SEG_BLANK;
		endcase
		return c;
	endfunction

	// tens in [6:4], ones in [3:0]
	function automatic logic [6:0] split_digits(input logic [5:0] v);
		logic [2:0] tens;
		logic [5:0] base;
		if (v >= 6'd60)      tens = 3'd6;
		else if (v >= 6'd50) tens = 3'd5;
		else if (v >= 6'd40) tens = 3'd4;
		else if (v >= 6'd30) tens = 3'd3;
		else if (v >= 6'd20) tens = 3'd2;
		else if (v >= 6'd10) tens = 3'd1;
		else                 tens = 3'd0;
		base = 6'({3'd0, tens} * 6'd10);
		return {tens, 4'(v - base)};
	endfunction

endpackage

### src/sccs_front.sv
// Front part: config registers, timeout counting, LED phase and halt decision.
// Depends on sccs_pkg; feeds classified items into sccs_queue.
module sccs_front import sccs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             timeout_flag,
	input  logic             button,
	input  logic [9:0]       switches,
	input  logic             q_full,
	output logic             q_push,
	output sccs_item_t       q_item
);

	localparam logic [1:0] PHASE_LED   = 2'd0;
	localparam logic [1:0] PHASE_CLOCK = 2'd1;
	localparam logic [1:0] PHASE_HALT  = 2'd2;

	logic [9:0]  tps_q;
	logic [9:0]  lps_q;
	logic [1:0]  phase_q;
	logic [9:0]  tc_q;
	logic [9:0]  led_q;

	logic        accept;
	logic [1:0]  phase_w;
	logic [9:0]  tc_w;
	logic [9:0]  limit;
	logic [10:0] tc_inc;
	logic        hit;
	logic [1:0]  phase_n;
	logic [9:0]  tc_n;
	logic [9:0]  led_n;
	logic        step;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign limit    = (tps_q == 10'd0) ? 10'd1 : tps_q;

	always_comb begin
		phase_w = phase_q;
		tc_w    = tc_q;
		if (phase_q == PHASE_LED && led_q >= lps_q) begin
			phase_w = PHASE_CLOCK;
			tc_w    = 10'd0;
		end
		tc_inc  = {1'b0, tc_w} + 11'd1;
		hit     = tc_inc >= {1'b0, limit};
		phase_n = phase_q;
		tc_n    = tc_q;
		led_n   = led_q;
		step    = 1'b0;
		if (accept && timeout_flag) begin
			phase_n = phase_w;
			tc_n    = hit ? 10'd0 : tc_inc[9:0];
			case (phase_w)
				PHASE_LED: begin
					if (hit) begin
						led_n = led_q + 10'd1;
						if (led_n >= lps_q) phase_n = PHASE_CLOCK;
					end
				end
				PHASE_CLOCK: begin
					if (hit) begin
						step = 1'b1;
						if (button && switches[7]) phase_n = PHASE_HALT;
					end
				end
				default: begin
					tc_n = tc_q;
				end
			endcase
		end
	end

	assign q_push          = accept;
	assign q_item.step     = step;
	assign q_item.button   = button;
	assign q_item.switches = switches;
	assign q_item.led      = led_n;
	assign q_item.halted   = phase_n[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RESET;
			lps_q   <= LPS_RESET;
			phase_q <= PHASE_LED;
			tc_q    <= 10'd0;
			led_q   <= 10'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUTS_PER_STEP: tps_q <= cfg_wdata;
					REG_LED_PHASE_STEPS:   lps_q <= cfg_wdata;
					default: ;
				endcase
			end
			phase_q <= phase_n;
			tc_q    <= tc_n;
			led_q   <= led_n;
		end
	end

	// LED count only moves during the LED phase
	a_led_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PHASE_LED && !cfg_we) |=> $stable(led_q))
		else $error("LED count moved outside LED phase");

	// once halted, the phase never leaves halt
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PHASE_HALT) |=> (phase_q == PHASE_HALT))
		else $error("halt phase left");

endmodule

### src/sccs_queue.sv
// Two-entry queue between the front and back parts.
// Depends on sccs_pkg for the item type.
module sccs_queue import sccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sccs_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output sccs_item_t pop_item
);

	sccs_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign valid    = count_q != 2'd0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");

endmodule

### src/sccs_back.sv
// Back part: time registers, field loading, rollover and digit redraw.
// Depends on sccs_pkg; drains sccs_queue into the output register.
module sccs_back import sccs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  sccs_item_t   q_item,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output sccs_result_t result
);

	logic         out_valid_q;
	sccs_result_t res_q;
	logic [5:0]   sec_q;
	logic [5:0]   min_q;
	logic [5:0]   hour_q;

	logic [6:0]   s_w;
	logic [6:0]   m_w;
	logic [6:0]   h_w;
	logic [5:0]   sec_n;
	logic [5:0]   min_n;
	logic [5:0]   hour_n;
	logic         redraw;
	logic [6:0]   sec_d;
	logic [6:0]   min_d;
	logic [6:0]   hour_d;
	logic [1:0]   sel;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = res_q;
	assign sel       = q_item.switches[9:8];

	always_comb begin
		sec_n  = sec_q;
		min_n  = min_q;
		hour_n = hour_q;
		redraw = 1'b0;
		s_w    = {1'b0, sec_q} + 7'd1;
		m_w    = {1'b0, min_q};
		h_w    = {1'b0, hour_q};
		if (s_w >= 7'd60) begin
			s_w = 7'd0;
			m_w = m_w + 7'd1;
		end
		if (m_w >= 7'd60) begin
			m_w = 7'd0;
			h_w = h_w + 7'd1;
		end
		if (h_w >= 7'd24) h_w = 7'd0;
		if (q_item.step) begin
			if (q_item.button) begin
				case (sel)
					SEL_SECONDS: sec_n  = q_item.switches[5:0];
					SEL_MINUTES: min_n  = q_item.switches[5:0];
					SEL_HOURS:   hour_n = q_item.switches[5:0];
					default: ;
				endcase
				redraw = !q_item.switches[7];
			end else begin
				sec_n  = s_w[5:0];
				min_n  = m_w[5:0];
				hour_n = h_w[5:0];
				redraw = 1'b1;
			end
		end
	end

	assign sec_d  = split_digits(sec_n);
	assign min_d  = split_digits(min_n);
	assign hour_d = split_digits(hour_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q         <= 1'b0;
			sec_q               <= 6'd0;
			min_q               <= 6'd0;
			hour_q              <= 6'd0;
			res_q.halted        <= 1'b0;
			res_q.led_pattern   <= 10'd0;
			res_q.seg_sec_ones  <= SEG_BLANK;
			res_q.seg_sec_tens  <= SEG_BLANK;
			res_q.seg_min_ones  <= SEG_BLANK;
			res_q.seg_min_tens  <= SEG_BLANK;
			res_q.seg_hour_ones <= SEG_BLANK;
			res_q.seg_hour_tens <= SEG_BLANK;
		end else begin
			if (q_pop) begin
				out_valid_q       <= 1'b1;
				sec_q             <= sec_n;
				min_q             <= min_n;
				hour_q            <= hour_n;
				res_q.halted      <= q_item.halted;
				res_q.led_pattern <= q_item.led;
				if (redraw) begin
					res_q.seg_sec_ones  <= seg_code(sec_d[3:0]);
					res_q.seg_sec_tens  <= seg_code({1'b0, sec_d[6:4]});
					res_q.seg_min_ones  <= seg_code(min_d[3:0]);
					res_q.seg_min_tens  <= seg_code({1'b0, min_d[6:4]});
					res_q.seg_hour_ones <= seg_code(hour_d[3:0]);
					res_q.seg_hour_tens <= seg_code({1'b0, hour_d[6:4]});
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// digits only change when a clock step is taken in
	a_digits_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_item.step) |=> $stable(res_q.seg_sec_ones))
		else $error("digits changed without a step");

endmodule

### src/settable_clock_seven_segment.sv
// Settable hh:mm:ss clock with start-up LED count, six seven-segment digits.
// Top level; depends on sccs_pkg, sccs_front, sccs_queue and sccs_back.
//
// Each sample accepted on the s_axis side gives exactly one result on the
// m_axis side, showing the state after that sample. One sample is taken every
// clock cycle when the output side keeps up. A result is presented once its
// item has passed through the two-entry queue into the output register: the
// accepting edge writes the queue, and the back part moves the item on when
// the output register is empty or being read. Config writes through
// cfg_we/cfg_index/cfg_wdata take effect at once and belong to idle periods.
module settable_clock_seven_segment import sccs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [0] timeout_flag, [1] button, [11:2] switches, [15:12] zero
	input  logic [15:0]      s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [6:0] seg_sec_ones, [13:7] seg_sec_tens, [20:14] seg_min_ones,
	// [27:21] seg_min_tens, [34:28] seg_hour_ones, [41:35] seg_hour_tens,
	// [51:42] led_pattern, [52] halted, [55:53] zero
	output logic [55:0]      m_axis_tdata
);

	logic         q_full;
	logic         q_push;
	sccs_item_t   push_item;
	logic         q_pop;
	logic         q_valid;
	sccs_item_t   pop_item;
	sccs_result_t result;

	sccs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.timeout_flag (s_axis_tdata[0]),
		.button       (s_axis_tdata[1]),
		.switches     (s_axis_tdata[11:2]),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (push_item)
	);

	sccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	sccs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {3'b000, result};

endmodule

### tb/tb_settable_clock_seven_segment.sv
// Self-checking testbench for settable_clock_seven_segment: a scoreboard class
// predicts each display transfer. Plain tasks drive the stream and register ports.
// Depends on sccs_pkg and the RTL top level only.
module tb_settable_clock_seven_segment;
	timeunit 1ns;
	timeprecision 1ps;
	import sccs_pkg::*;

	typedef enum logic [1:0] {PH_LED = 2'd0, PH_CLOCK = 2'd1, PH_HALT = 2'd2} clock_phase_e;

	localparam logic [1:0] SEL_NONE = 2'd0;

	class clock_scoreboard;
		logic [9:0] steps_div;
		logic [9:0] led_limit;
		logic [9:0] tick_count;
		logic [9:0] led_count;
		clock_phase_e phase;
		logic [5:0] sec;
		logic [5:0] mins;
		logic [5:0] hrs;
		logic [6:0] digit_seg [6];
		sccs_result_t display_q [$];
		int mismatches;

		function new();
			steps_div = TPS_RESET;
			led_limit = LPS_RESET;
			tick_count = '0;
			led_count = '0;
			phase = PH_LED;
			sec = '0;
			mins = '0;
			hrs = '0;
			foreach (digit_seg[k]) digit_seg[k] = SEG_BLANK;
			mismatches = 0;
		endfunction

		function void write_reg(logic [0:0] idx, logic [9:0] v);
			if (idx == REG_TIMEOUTS_PER_STEP) begin
				steps_div = v;
			end else begin
				led_limit = v;
			end
		endfunction

		function logic [6:0] seg_of(int d);
			case (d)
				0: return 7'h40;
				1: return 7'h79;
				2: return 7'h24;
				3: return 7'h30;
				4: return 7'h19;
				5: return 7'h12;
				6: return 7'h02;
				7: return 7'h78;
				8: return 7'h00;
				9: return 7'h10;
				default: return SEG_BLANK;
			endcase
		endfunction

		function void redraw();
			digit_seg[0] = seg_of(sec % 10);
			digit_seg[1] = seg_of(sec / 10);
			digit_seg[2] = seg_of(mins % 10);
			digit_seg[3] = seg_of(mins / 10);
			digit_seg[4] = seg_of(hrs % 10);
			digit_seg[5] = seg_of(hrs / 10);
		endfunction

		// a divider of zero behaves as one; an incremented count at or above the divider steps
		function bit count_tick();
			int lim;
			lim = (steps_div == 10'd0) ? 1 : int'(steps_div);
			if (int'(tick_count) + 1 >= lim) begin
				tick_count = '0;
				return 1'b1;
			end
			tick_count = tick_count + 10'd1;
			return 1'b0;
		endfunction

		function void clock_step(bit button, logic [9:0] sw);
			int s;
			int m;
			int h;
			if (button) begin
				case (sw[9:8])
					SEL_SECONDS: sec = sw[5:0];
					SEL_MINUTES: mins = sw[5:0];
					SEL_HOURS: hrs = sw[5:0];
					default: ;
				endcase
				if (sw[7]) begin
					phase = PH_HALT;
					return;
				end
			end else begin
				s = int'(sec) + 1;
				m = int'(mins);
				h = int'(hrs);
				if (s >= 60) begin
					s = 0;
					m++;
				end
				if (m >= 60) begin
					m = 0;
					h++;
				end
				if (h >= 24) h = 0;
				sec = 6'(s);
				mins = 6'(m);
				hrs = 6'(h);
			end
			redraw();
		endfunction

		function void note_input(logic [15:0] d);
			sccs_result_t r;
			if (d[0]) begin
				if (phase == PH_LED && led_count >= led_limit) begin
					phase = PH_CLOCK;
					tick_count = '0;
				end
				if (phase == PH_LED) begin
					if (count_tick()) begin
						led_count = led_count + 10'd1;
						if (led_count >= led_limit) begin
							phase = PH_CLOCK;
							tick_count = '0;
						end
					end
				end else if (phase == PH_CLOCK) begin
					if (count_tick()) clock_step(d[1], d[11:2]);
				end
			end
			r.seg_sec_ones = digit_seg[0];
			r.seg_sec_tens = digit_seg[1];
			r.seg_min_ones = digit_seg[2];
			r.seg_min_tens = digit_seg[3];
			r.seg_hour_ones = digit_seg[4];
			r.seg_hour_tens = digit_seg[5];
			r.led_pattern = led_count;
			r.halted = (phase == PH_HALT);
			display_q.push_back(r);
		endfunction

		function void check_result(logic [55:0] d);
			sccs_result_t got;
			sccs_result_t want;
			logic [9:0] g [8];
			logic [9:0] w [8];
			string nm [8];
			bit bad;
			got = sccs_result_t'(d[52:0]);
			if (display_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer, data %h", d);
				return;
			end
			want = display_q.pop_front();
			nm = '{"seg_sec_ones", "seg_sec_tens", "seg_min_ones", "seg_min_tens",
				"seg_hour_ones", "seg_hour_tens", "led_pattern", "halted"};
			g = '{got.seg_sec_ones, got.seg_sec_tens, got.seg_min_ones, got.seg_min_tens,
				got.seg_hour_ones, got.seg_hour_tens, got.led_pattern, got.halted};
			w = '{want.seg_sec_ones, want.seg_sec_tens, want.seg_min_ones, want.seg_min_tens,
				want.seg_hour_ones, want.seg_hour_tens, want.led_pattern, want.halted};
			bad = 1'b0;
			foreach (g[k]) if (g[k] !== w[k]) bad = 1'b1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("display mismatch at %0t", $realtime);
					foreach (g[k]) begin
						if (g[k] !== w[k]) begin
							$display("  %s: expected %h, got %h", nm[k], w[k], g[k]);
						end
					end
				end
			end
		endfunction

		function int pending();
			return display_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [55:0] m_axis_tdata;

	clock_scoreboard board = new();
	bit tx_idle_on;
	bit rx_idle_on;
	bit long_hold_req;

	settable_clock_seven_segment i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb_settable_clock_seven_segment: done, errors");
		$finish;
	end

	// display side: random stall per transfer when enabled, plus one long hold on request
	initial begin : display_sink
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_idle_on ? $urandom_range(0, 10) : 0;
			if (long_hold_req) begin
				gap = 400;
				long_hold_req = 1'b0;
			end
			@(negedge clk);
			repeat (gap) begin
				m_axis_tready <= 1'b0;
				@(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_result(m_axis_tdata);
		end
	end

	function automatic logic [9:0] set_sw(input logic [1:0] sel, input bit stop,
			input logic [5:0] val);
		return {sel, stop, 1'b0, val};
	endfunction

	task automatic send_item(input bit flag, input bit button, input logic [9:0] sw);
		logic [15:0] d;
		int gap;
		d = {4'b0000, sw, button, flag};
		gap = tx_idle_on ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(d);
	endtask

	// drop valid and wait until every display transfer is back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [9:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, v);
	endtask

	// halting loads stay out unless asked for, so the clock keeps running
	task automatic send_random(input int n, input bit allow_halt);
		bit flag;
		bit button;
		logic [9:0] sw;
		repeat (n) begin
			flag = ($urandom_range(0, 99) < 85);
			button = ($urandom_range(0, 99) < 30);
			sw = 10'($urandom_range(0, 1023));
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 5))
					0: sw[5:0] = 6'd59;
					1: sw[5:0] = 6'd60;
					2: sw[5:0] = 6'd63;
					3: sw[5:0] = 6'd23;
					4: sw[5:0] = 6'd24;
					default: sw[5:0] = 6'd0;
				endcase
			end
			if (button && flag && !allow_halt) sw[7] = 1'b0;
			send_item(flag, button, sw);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TIMEOUTS_PER_STEP;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		long_hold_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// LED phase at reset settings
		send_item(1'b0, 1'b1, 10'h3FF);
		send_item(1'b0, 1'b0, 10'h000);
		repeat (10) send_item(1'b1, 1'b1, 10'h3FF);
		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd0);
		if ($urandom_range(0, 1) == 1) begin
			write_reg(REG_LED_PHASE_STEPS, 10'd0);
		end else begin
			write_reg(REG_LED_PHASE_STEPS, 10'd2);
		end
		send_item(1'b1, 1'b0, 10'h000);
		send_item(1'b1, 1'b0, 10'h000);
		send_item(1'b1, 1'b1, set_sw(SEL_SECONDS, 1'b0, 6'd63));
		send_item(1'b1, 1'b0, 10'h000);
		send_item(1'b1, 1'b1, set_sw(SEL_MINUTES, 1'b0, 6'd59));
		send_item(1'b1, 1'b1, set_sw(SEL_HOURS, 1'b0, 6'd23));
		send_item(1'b1, 1'b1, set_sw(SEL_SECONDS, 1'b0, 6'd59));
		send_item(1'b1, 1'b0, 10'h000);
		send_item(1'b1, 1'b1, set_sw(SEL_NONE, 1'b0, 6'd63));
		send_item(1'b1, 1'b1, set_sw(SEL_HOURS, 1'b0, 6'd63));
		send_item(1'b1, 1'b0, 10'h000);
		send_item(1'b1, 1'b1, set_sw(SEL_MINUTES, 1'b0, 6'd63));
		send_item(1'b1, 1'b0, 10'h000);
		send_item(1'b0, 1'b1, set_sw(SEL_HOURS, 1'b1, 6'd5));

		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd1);
		write_reg(REG_LED_PHASE_STEPS, 10'd1023);
		send_random(300, 1'b0);

		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd2);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_random(250, 1'b0);

		// output held off while the input keeps offering
		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd1023);
		write_reg(REG_LED_PHASE_STEPS, 10'd16);
		rx_idle_on = 1'b1;
		long_hold_req = 1'b1;
		send_random(300, 1'b0);

		// divider lowered below the running count
		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd3);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		send_random(200, 1'b0);

		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd0);
		rx_idle_on = 1'b1;
		send_random(250, 1'b0);

		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd7);
		send_random(150, 1'b0);

		settle();
		write_reg(REG_TIMEOUTS_PER_STEP, 10'd1);
		send_random(30, 1'b0);
		send_item(1'b1, 1'b1, set_sw(2'($urandom_range(0, 3)), 1'b1,
			6'($urandom_range(0, 63))));
		send_random(40, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("tb_settable_clock_seven_segment: done, clean");
		end else begin
			$display("tb_settable_clock_seven_segment: done, errors");
		end
		$finish;
	end
endmodule
